FILE: rtl/sacl_pkg.sv
// Shared types, codes and constants of the set-associative LRU cache model.
// Used by every module under rtl but sacl_tag_store; depends on nothing else.
package sacl_pkg;

    // Defaults for the top-level module parameters.
    localparam int DEF_MAX_SET_BITS = 8;
    localparam int DEF_MAX_WAYS     = 8;
    localparam int DEF_ADDR_WIDTH   = 48;

    // Fixed field widths.
    localparam int ADDR_FIELD_W = 48;
    localparam int CNT_W        = 32;
    localparam int AGE_W        = 3;
    localparam logic [AGE_W-1:0] AGE_MAX = 3'd7;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SET_BITS    = 2'd0,
        CFG_OFFSET_BITS = 2'd1,
        CFG_WAYS        = 2'd2
    } cfg_reg_t;

    localparam logic [CFG_DATA_W-1:0] CFG_SET_BITS_RST    = 4'd4;
    localparam logic [CFG_DATA_W-1:0] CFG_OFFSET_BITS_RST = 4'd4;
    localparam logic [CFG_DATA_W-1:0] CFG_WAYS_RST        = 4'd1;

    // Bit of the op field that requests the second (store) access of a modify.
    localparam int OP_SECOND_BIT = 1;

    // Result of the first access.
    typedef enum logic [1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2
    } outcome_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR  = 3'd0,
        ST_IDLE   = 3'd1,
        ST_SPLIT  = 3'd2,
        ST_LOOKUP = 3'd3,
        ST_UPDATE = 3'd4
    } sacl_state_t;

    // Input transaction payload.
    typedef struct packed {
        logic [1:0]              op;
        logic [ADDR_FIELD_W-1:0] address;
    } sacl_in_t;

    // Result transaction payload.
    typedef struct packed {
        logic [1:0]       outcome;
        logic             second_hit;
        logic [2:0]       way_used;
        logic [CNT_W-1:0] hits_total;
        logic [CNT_W-1:0] misses_total;
        logic [CNT_W-1:0] evictions_total;
    } sacl_out_t;

endpackage

FILE: rtl/sacl_tag_store.sv
// Tag memory, one entry per set and way, with the shared tag comparator.
// Depends on no package; read data is registered.
module sacl_tag_store #(
    parameter int SET_BITS = 8,
    parameter int WAY_W    = 3,
    parameter int TAG_W    = 48
) (
    input  logic                      aclk,
    input  logic                      rd_en,
    input  logic [SET_BITS+WAY_W-1:0] rd_addr,
    input  logic                      wr_en,
    input  logic [SET_BITS+WAY_W-1:0] wr_addr,
    input  logic [TAG_W-1:0]          wr_tag,
    input  logic [TAG_W-1:0]          cmp_tag,
    output logic                      match
);
    localparam int Depth = 1 << (SET_BITS + WAY_W);

    logic [TAG_W-1:0] tag_mem [Depth];
    logic [TAG_W-1:0] rd_tag_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tag_mem[wr_addr] <= wr_tag;
        end
        if (rd_en) begin
            rd_tag_reg <= tag_mem[rd_addr];
        end
    end

    // The single comparator, reused for every way of a lookup.
    assign match = (rd_tag_reg == cmp_tag);

endmodule

FILE: rtl/sacl_meta_store.sv
// Per-set metadata memory: a valid bit and an LRU age for every way of a set.
// Depends on sacl_pkg for the age width; one row read and one row write per cycle.
module sacl_meta_store #(
    parameter int SET_BITS = 8,
    parameter int WAYS     = 8
) (
    input  logic                                  aclk,
    input  logic                                  rd_en,
    input  logic [SET_BITS-1:0]                   rd_addr,
    output logic [WAYS-1:0]                       rd_valid,
    output logic [WAYS-1:0][sacl_pkg::AGE_W-1:0]  rd_age,
    input  logic                                  wr_en,
    input  logic [SET_BITS-1:0]                   wr_addr,
    input  logic [WAYS-1:0]                       wr_valid,
    input  logic [WAYS-1:0][sacl_pkg::AGE_W-1:0]  wr_age
);
    import sacl_pkg::*;

    localparam int NumSets = 1 << SET_BITS;

    typedef struct packed {
        logic [WAYS-1:0][AGE_W-1:0] age;
        logic [WAYS-1:0]            valid;
    } meta_row_t;

    meta_row_t meta_mem [NumSets];
    meta_row_t rd_row_reg;

    // Row write and registered row read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            meta_mem[wr_addr] <= '{age: wr_age, valid: wr_valid};
        end
        if (rd_en) begin
            rd_row_reg <= meta_mem[rd_addr];
        end
    end

    assign rd_valid = rd_row_reg.valid;
    assign rd_age   = rd_row_reg.age;

endmodule

FILE: rtl/sacl_lru_update.sv
// Replacement and age-update logic for one set row: picks the way and new ages.
// Depends on sacl_pkg for the age width, the age limit and the outcome codes.
module sacl_lru_update #(
    parameter int WAYS  = 8,
    parameter int WAY_W = 3,
    parameter int CNT_W = 4
) (
    input  logic [WAYS-1:0]                       valid_in,
    input  logic [WAYS-1:0][sacl_pkg::AGE_W-1:0]  age_in,
    input  logic [CNT_W-1:0]                      nways,
    input  logic                                  hit,
    input  logic [WAY_W-1:0]                      hit_way,
    output logic [WAY_W-1:0]                      way_sel,
    output sacl_pkg::outcome_t                    outcome,
    output logic [WAYS-1:0]                       valid_out,
    output logic [WAYS-1:0][sacl_pkg::AGE_W-1:0]  age_out
);
    import sacl_pkg::*;

    localparam int OldAgeW = AGE_W + 1;

    logic               empty_found;
    logic [WAY_W-1:0]   empty_way;
    logic [AGE_W-1:0]   best_age;
    logic [WAY_W-1:0]   victim_way;
    logic [OldAgeW-1:0] old_age;

    // Lowest invalid way, and the oldest way (lowest index on ties).
    always_comb begin
        empty_found = 1'b0;
        empty_way   = '0;
        best_age    = '0;
        victim_way  = '0;
        for (int j = 0; j < WAYS; j++) begin
            if (j < int'(nways)) begin
                if (!empty_found && !valid_in[j]) begin
                    empty_found = 1'b1;
                    empty_way   = WAY_W'(j);
                end
                if (age_in[j] > best_age) begin
                    best_age   = age_in[j];
                    victim_way = WAY_W'(j);
                end
            end
        end
    end

    // Way choice; a fill of an empty way ranks older than every valid way.
    always_comb begin
        if (hit) begin
            way_sel = hit_way;
            old_age = {1'b0, age_in[hit_way]};
            outcome = OUT_HIT;
        end else if (empty_found) begin
            way_sel = empty_way;
            old_age = OldAgeW'(AGE_MAX) + OldAgeW'(1);
            outcome = OUT_FILL;
        end else begin
            way_sel = victim_way;
            old_age = {1'b0, best_age};
            outcome = OUT_EVICT;
        end
    end

    // Ways younger than the touched way grow one older; the touched way becomes newest.
    always_comb begin
        valid_out = valid_in;
        age_out   = age_in;
        for (int j = 0; j < WAYS; j++) begin
            if (j < int'(nways) && WAY_W'(j) != way_sel && valid_in[j] &&
                {1'b0, age_in[j]} < old_age && age_in[j] != AGE_MAX) begin
                age_out[j] = age_in[j] + AGE_W'(1);
            end
        end
        age_out[way_sel]   = '0;
        valid_out[way_sel] = 1'b1;
    end

endmodule

FILE: rtl/set_assoc_cache_lru_sim.sv
// Top level of the set-associative cache model with true LRU replacement.
// Depends on sacl_pkg, sacl_tag_store, sacl_meta_store and sacl_lru_update.
//
//   Channel  Ports                              Direction  Transaction
//   input    s_valid, s_ready, s_data           in         op and byte address
//   result   m_valid, m_ready, m_data           out        outcome, way, totals
//   config   cfg_valid, cfg_ready, cfg_index,   in         register write
//            cfg_data
//
// An access runs through the split step, a lookup of k ways and the update step, where k is the
// number of ways the single tag comparator visits: the hit way plus one on a hit,
// and the ways in use on a miss (one way per cycle). The next access is taken
// in the idle state, which is entered as the result is loaded.
// After reset the metadata memory is cleared one set per cycle, all 2^MAX_SET_BITS
// sets (256 by default), with s_ready low; configuration writes are taken.
// A stalled result holds the block in its update step until m_ready is high.
module set_assoc_cache_lru_sim #(
    parameter int MAX_SET_BITS = sacl_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = sacl_pkg::DEF_MAX_WAYS,
    parameter int ADDR_WIDTH   = sacl_pkg::DEF_ADDR_WIDTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  sacl_pkg::sacl_in_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output sacl_pkg::sacl_out_t               m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sacl_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sacl_pkg::*;

    localparam int AddrW  = (ADDR_WIDTH < ADDR_FIELD_W) ? ADDR_WIDTH : ADDR_FIELD_W;
    localparam int WayW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CntW   = $clog2(MAX_WAYS + 1);
    localparam int SetBW  = $clog2(MAX_SET_BITS + 1);
    localparam int ShamtW = 5;
    localparam int TagAW  = MAX_SET_BITS + WayW;

    // Saturating add of a small increment to a running total.
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
                                                  input logic [1:0] inc);
        logic [CNT_W:0] sum;
        sum = {1'b0, v} + (CNT_W + 1)'(inc);
        return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    endfunction

    // Control and configuration state.
    sacl_state_t             state_reg, state_next;
    logic [CFG_DATA_W-1:0]   cfg_set_reg, cfg_off_reg, cfg_ways_reg;
    logic [MAX_SET_BITS-1:0] clr_cnt_reg;
    logic [CNT_W-1:0]        hit_cnt_reg, hit_cnt_next;
    logic [CNT_W-1:0]        miss_cnt_reg, miss_cnt_next;
    logic [CNT_W-1:0]        evict_cnt_reg, evict_cnt_next;
    logic                    m_valid_reg;
    sacl_out_t               m_data_reg, m_data_next;

    // Per-access datapath registers.
    logic [1:0]              op_reg;
    logic [AddrW-1:0]        addr_reg;
    logic [MAX_SET_BITS-1:0] set_reg, set_next;
    logic [AddrW-1:0]        tag_reg, tag_next;
    logic [CntW-1:0]         nways_reg, nways_next;
    logic [CntW-1:0]         way_cnt_reg;
    logic                    hit_reg;
    logic [WayW-1:0]         hit_way_reg;

    // Address split and configuration clamping.
    logic [SetBW-1:0]        set_bits_eff;
    logic [MAX_SET_BITS-1:0] set_mask;
    logic [AddrW-1:0]        addr_off_shift;
    logic [ShamtW-1:0]       tag_shamt;

    // Memory and replacement connections.
    logic                         meta_rd_en, meta_wr_en;
    logic [MAX_SET_BITS-1:0]      meta_wr_addr;
    logic [MAX_WAYS-1:0]          meta_valid, meta_wr_valid;
    logic [MAX_WAYS-1:0][AGE_W-1:0] meta_age, meta_wr_age;
    logic                         tag_rd_en, tag_wr_en, tag_match;
    logic [TagAW-1:0]             tag_rd_addr;
    logic [WayW-1:0]              lru_way;
    outcome_t                     lru_outcome;
    logic [MAX_WAYS-1:0]          lru_valid;
    logic [MAX_WAYS-1:0][AGE_W-1:0] lru_age;

    logic way_hit, last_way, upd_go;
    logic [1:0] hit_inc;

    // Clamp the set bit count and the way count, then split the address.
    always_comb begin
        if (int'(cfg_set_reg) > MAX_SET_BITS) begin
            set_bits_eff = SetBW'(MAX_SET_BITS);
        end else begin
            set_bits_eff = SetBW'(cfg_set_reg);
        end
        if (cfg_ways_reg == '0) begin
            nways_next = CntW'(1);
        end else if (int'(cfg_ways_reg) > MAX_WAYS) begin
            nways_next = CntW'(MAX_WAYS);
        end else begin
            nways_next = CntW'(cfg_ways_reg);
        end
        set_mask       = ~({MAX_SET_BITS{1'b1}} << set_bits_eff);
        addr_off_shift = addr_reg >> cfg_off_reg;
        set_next       = addr_off_shift[MAX_SET_BITS-1:0] & set_mask;
        tag_shamt      = ShamtW'(set_bits_eff) + ShamtW'(cfg_off_reg);
        tag_next       = addr_reg >> tag_shamt;
    end

    // Lookup status of the way under compare.
    assign way_hit  = (state_reg == ST_LOOKUP) && tag_match &&
                      meta_valid[way_cnt_reg[WayW-1:0]];
    assign last_way = (way_cnt_reg == (nways_reg - CntW'(1)));
    assign upd_go   = !m_valid_reg || m_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (&clr_cnt_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SPLIT;
                end
            end
            ST_SPLIT: begin
                state_next = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                if (way_hit || last_way) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (upd_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: handshake and memory port controls.
    always_comb begin
        s_ready       = 1'b0;
        meta_rd_en    = 1'b0;
        meta_wr_en    = 1'b0;
        meta_wr_addr  = set_reg;
        meta_wr_valid = lru_valid;
        meta_wr_age   = lru_age;
        tag_rd_en     = 1'b0;
        tag_rd_addr   = {set_reg, WayW'(way_cnt_reg + CntW'(1))};
        tag_wr_en     = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                meta_wr_en    = 1'b1;
                meta_wr_addr  = clr_cnt_reg;
                meta_wr_valid = '0;
                meta_wr_age   = '0;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_SPLIT: begin
                meta_rd_en  = 1'b1;
                tag_rd_en   = 1'b1;
                tag_rd_addr = {set_next, {WayW{1'b0}}};
            end
            ST_LOOKUP: begin
                tag_rd_en = 1'b1;
            end
            ST_UPDATE: begin
                meta_wr_en = upd_go;
                tag_wr_en  = upd_go && !hit_reg;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Totals and the result word for the finished access.
    always_comb begin
        hit_inc        = 2'(hit_reg) + 2'(op_reg[OP_SECOND_BIT]);
        hit_cnt_next   = sat_add(hit_cnt_reg, hit_inc);
        miss_cnt_next  = sat_add(miss_cnt_reg, 2'(!hit_reg));
        evict_cnt_next = sat_add(evict_cnt_reg, 2'(lru_outcome == OUT_EVICT));
        m_data_next.outcome         = lru_outcome;
        m_data_next.second_hit      = op_reg[OP_SECOND_BIT];
        m_data_next.way_used        = 3'(lru_way);
        m_data_next.hits_total      = hit_cnt_next;
        m_data_next.misses_total    = miss_cnt_next;
        m_data_next.evictions_total = evict_cnt_next;
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            cfg_set_reg   <= CFG_SET_BITS_RST;
            cfg_off_reg   <= CFG_OFFSET_BITS_RST;
            cfg_ways_reg  <= CFG_WAYS_RST;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + MAX_SET_BITS'(1);
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_SET_BITS:    cfg_set_reg  <= cfg_data;
                    CFG_OFFSET_BITS: cfg_off_reg  <= cfg_data;
                    CFG_WAYS:        cfg_ways_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (state_reg == ST_UPDATE && upd_go) begin
                hit_cnt_reg   <= hit_cnt_next;
                miss_cnt_reg  <= miss_cnt_next;
                evict_cnt_reg <= evict_cnt_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= s_data.op;
            addr_reg <= s_data.address[AddrW-1:0];
        end
        if (state_reg == ST_SPLIT) begin
            set_reg     <= set_next;
            tag_reg     <= tag_next;
            nways_reg   <= nways_next;
            way_cnt_reg <= '0;
            hit_reg     <= 1'b0;
        end
        if (state_reg == ST_LOOKUP) begin
            way_cnt_reg <= way_cnt_reg + CntW'(1);
            if (way_hit) begin
                hit_reg     <= 1'b1;
                hit_way_reg <= way_cnt_reg[WayW-1:0];
            end
        end
        if (state_reg == ST_UPDATE && upd_go) begin
            m_data_reg <= m_data_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    sacl_meta_store #(
        .SET_BITS (MAX_SET_BITS),
        .WAYS     (MAX_WAYS)
    ) u_meta (
        .aclk     (aclk),
        .rd_en    (meta_rd_en),
        .rd_addr  (set_next),
        .rd_valid (meta_valid),
        .rd_age   (meta_age),
        .wr_en    (meta_wr_en),
        .wr_addr  (meta_wr_addr),
        .wr_valid (meta_wr_valid),
        .wr_age   (meta_wr_age)
    );

    sacl_tag_store #(
        .SET_BITS (MAX_SET_BITS),
        .WAY_W    (WayW),
        .TAG_W    (AddrW)
    ) u_tags (
        .aclk    (aclk),
        .rd_en   (tag_rd_en),
        .rd_addr (tag_rd_addr),
        .wr_en   (tag_wr_en),
        .wr_addr ({set_reg, lru_way}),
        .wr_tag  (tag_reg),
        .cmp_tag (tag_reg),
        .match   (tag_match)
    );

    sacl_lru_update #(
        .WAYS  (MAX_WAYS),
        .WAY_W (WayW),
        .CNT_W (CntW)
    ) u_lru (
        .valid_in  (meta_valid),
        .age_in    (meta_age),
        .nways     (nways_reg),
        .hit       (hit_reg),
        .hit_way   (hit_way_reg),
        .way_sel   (lru_way),
        .outcome   (lru_outcome),
        .valid_out (lru_valid),
        .age_out   (lru_age)
    );

    // An accepted transaction always starts with the address split.
    a_accept_to_split: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_SPLIT))
        else $error("Accepted transaction did not enter the split step.");

    // The way counter never runs past the ways in use during a lookup.
    a_lookup_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOKUP) |-> (way_cnt_reg < nways_reg))
        else $error("Lookup way counter beyond the ways in use.");

    // Totals move only when an access completes.
    a_totals_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_UPDATE) |=> ($stable(hit_cnt_reg) && $stable(miss_cnt_reg) &&
                                      $stable(evict_cnt_reg)))
        else $error("Totals changed outside the update step.");

    // A completed miss below saturation adds exactly one to the miss total.
    a_miss_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPDATE && upd_go && !hit_reg && miss_cnt_reg != {CNT_W{1'b1}})
        |=> (miss_cnt_reg == $past(miss_cnt_reg) + CNT_W'(1)))
        else $error("Miss total not incremented on a miss.");

endmodule

FILE: dv/set_assoc_cache_lru_sim_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for set_assoc_cache_lru_sim: random and directed accesses
// checked against an LRU cache predictor kept in a scoreboard class.
// Depends on sacl_pkg and the RTL top level set_assoc_cache_lru_sim.
module set_assoc_cache_lru_sim_tb;
    import sacl_pkg::*;

    localparam int MAX_SET_BITS      = DEF_MAX_SET_BITS;
    localparam int MAX_WAYS          = DEF_MAX_WAYS;
    localparam int LINE_COUNT        = (1 << MAX_SET_BITS) * MAX_WAYS;
    localparam int WATCHDOG_LIMIT    = 3000;
    localparam int LONG_HOLD_CYCLES  = 150;
    localparam int DRAIN_TAIL_CYCLES = 20;
    localparam int POOL_MAX          = 12;

    // Access kinds; the fourth code has no meaning of its own and behaves as a modify.
    localparam logic [1:0] OP_LOAD       = 2'd0;
    localparam logic [1:0] OP_STORE      = 2'd1;
    localparam logic [1:0] OP_MODIFY     = 2'd2;
    localparam logic [1:0] OP_MODIFY_ALT = 2'd3;

    // Predicts cache results from accepted accesses and checks the block's results.
    class cache_scoreboard;
        bit                      line_valid [LINE_COUNT];
        logic [ADDR_FIELD_W-1:0] line_tag   [LINE_COUNT];
        logic [AGE_W-1:0]        line_age   [LINE_COUNT];
        logic [CNT_W-1:0]        hit_total, miss_total, evict_total;
        logic [CFG_DATA_W-1:0]   set_bits_reg, offset_bits_reg, ways_reg;
        sacl_out_t               pending_results [$];
        int                      mismatches, hit_count, fill_count, evict_count;

        function new();
            foreach (line_age[i]) begin
                line_valid[i] = 1'b0;
                line_age[i]   = '0;
            end
            hit_total       = '0;
            miss_total      = '0;
            evict_total     = '0;
            set_bits_reg    = CFG_SET_BITS_RST;
            offset_bits_reg = CFG_OFFSET_BITS_RST;
            ways_reg        = CFG_WAYS_RST;
            mismatches      = 0;
            hit_count       = 0;
            fill_count      = 0;
            evict_count     = 0;
        endfunction

        function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] value);
            return (value == '1) ? value : value + 1'b1;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_SET_BITS:    set_bits_reg    = value;
                CFG_OFFSET_BITS: offset_bits_reg = value;
                CFG_WAYS:        ways_reg        = value;
                default: ;
            endcase
        endfunction

        // Runs one access through the cache copy and queues the result it must produce.
        function void note_access(sacl_in_t item);
            int                      s, b, nways, set_idx, base, way, old_age, best, j;
            bit                      found, empty;
            logic [ADDR_FIELD_W-1:0] tag;
            sacl_out_t               want;

            s       = (set_bits_reg > MAX_SET_BITS) ? MAX_SET_BITS : int'(set_bits_reg);
            b       = int'(offset_bits_reg);
            nways   = (ways_reg == 0) ? 1 : ((ways_reg > MAX_WAYS) ? MAX_WAYS : int'(ways_reg));
            set_idx = int'((item.address >> b) & ((48'd1 << s) - 48'd1));
            tag     = item.address >> (s + b);
            base    = set_idx * MAX_WAYS;
            found   = 1'b0;
            empty   = 1'b0;
            way     = 0;
            old_age = 0;
            want    = '0;

            // Lookup: the lowest-numbered valid way in use with a matching tag wins.
            for (j = 0; j < nways; j++) begin
                if (!found && line_valid[base + j] && line_tag[base + j] == tag) begin
                    way   = j;
                    found = 1'b1;
                end
            end

            if (found) begin
                want.outcome = OUT_HIT;
                hit_total    = bump(hit_total);
                old_age      = int'(line_age[base + way]);
                hit_count++;
            end else begin
                miss_total = bump(miss_total);
                for (j = 0; j < nways; j++) begin
                    if (!empty && !line_valid[base + j]) begin
                        way   = j;
                        empty = 1'b1;
                    end
                end
                if (empty) begin
                    // A fill ranks as older than every valid way.
                    want.outcome = OUT_FILL;
                    old_age      = AGE_MAX + 1;
                    fill_count++;
                end else begin
                    // The oldest way goes, lowest index on ties.
                    want.outcome = OUT_EVICT;
                    evict_total  = bump(evict_total);
                    best         = 0;
                    for (j = 0; j < nways; j++) begin
                        if (line_age[base + j] > best) begin
                            best = int'(line_age[base + j]);
                            way  = j;
                        end
                    end
                    old_age = best;
                    evict_count++;
                end
            end

            // LRU refresh: younger valid ways age by one, the accessed way becomes newest.
            for (j = 0; j < nways; j++) begin
                if (j != way && line_valid[base + j] && line_age[base + j] < old_age &&
                    line_age[base + j] < AGE_MAX) begin
                    line_age[base + j] = line_age[base + j] + 1'b1;
                end
            end
            line_age[base + way] = '0;
            if (!found) begin
                line_valid[base + way] = 1'b1;
                line_tag[base + way]   = tag;
            end

            // The second access of a modify always hits.
            if (item.op[OP_SECOND_BIT]) begin
                hit_total = bump(hit_total);
            end
            want.second_hit      = item.op[OP_SECOND_BIT];
            want.way_used        = 3'(way);
            want.hits_total      = hit_total;
            want.misses_total    = miss_total;
            want.evictions_total = evict_total;
            pending_results.push_back(want);
        endfunction

        function void compare_field(string name, logic [CNT_W-1:0] want,
                                    logic [CNT_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        // Compares a result transaction with the oldest prediction.
        function void check_result(sacl_out_t got);
            sacl_out_t want;
            if (pending_results.size() == 0) begin
                $error("result transaction with no access outstanding: %h", got);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("outcome", want.outcome, got.outcome);
            compare_field("second_hit", want.second_hit, got.second_hit);
            compare_field("way_used", want.way_used, got.way_used);
            compare_field("hits_total", want.hits_total, got.hits_total);
            compare_field("misses_total", want.misses_total, got.misses_total);
            compare_field("evictions_total", want.evictions_total, got.evictions_total);
        endfunction
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    sacl_in_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    sacl_out_t              m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_SET_BITS;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    cache_scoreboard sb;
    int burst_left     = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int idle_cycles    = 0;
    int settings_used  = 0;

    set_assoc_cache_lru_sim dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Result monitor.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_data);
        end
    end

    // Watchdog: counts cycles in which no transaction completes on any channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $error("no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Result receiver: stall segments of random style, plus long hold-offs on request.
    initial begin : receiver
        int seg_left;
        int style;
        seg_left = 0;
        style    = 0;
        forever begin
            @(posedge aclk);
            if (holds_served < hold_requests) begin
                holds_served++;
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(posedge aclk);
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(4, 48);
                    style    = $urandom_range(0, 2);
                end
                seg_left--;
                case (style)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offers one access transaction, with burst gaps, and records it once accepted.
    task automatic offer_access(input logic [1:0] op, input logic [ADDR_FIELD_W-1:0] addr);
        int       gap;
        sacl_in_t item;
        item.op      = op;
        item.address = addr;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_access(item);
    endtask

    // Stops offering and waits until every predicted result has arrived.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, value);
    endtask

    // Writes all three registers back to back; the block must be idle.
    task automatic write_config(input logic [CFG_DATA_W-1:0] set_bits,
                                input logic [CFG_DATA_W-1:0] offset_bits,
                                input logic [CFG_DATA_W-1:0] ways);
        write_reg(CFG_SET_BITS, set_bits);
        write_reg(CFG_OFFSET_BITS, offset_bits);
        write_reg(CFG_WAYS, ways);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // One register setting followed by random accesses. Most addresses reuse a small
    // pool of tags over a few sets so lines hit, fill and evict; the rest are noise.
    task automatic run_phase(input logic [CFG_DATA_W-1:0] set_bits,
                             input logic [CFG_DATA_W-1:0] offset_bits,
                             input logic [CFG_DATA_W-1:0] ways,
                             input int count, input bit long_hold);
        int                      s, nways, pool_size, last_set, i;
        logic [ADDR_FIELD_W-1:0] tag_pool [POOL_MAX];
        logic [ADDR_FIELD_W-1:0] addr;

        drain();
        write_config(set_bits, offset_bits, ways);
        s         = (set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(set_bits);
        nways     = (ways == 0) ? 1 : ((ways > MAX_WAYS) ? MAX_WAYS : int'(ways));
        pool_size = nways + $urandom_range(0, 3);
        last_set  = ((1 << s) - 1 < 3) ? (1 << s) - 1 : 3;
        for (i = 0; i < pool_size; i++) begin
            tag_pool[i] = 48'({$urandom, $urandom});
        end

        for (i = 0; i < count; i++) begin
            // The receiver holds off while offers continue, so the block backs up.
            if (long_hold && i == 5) begin
                hold_requests++;
            end
            if (i == count / 2) begin
                drain();
            end
            if ($urandom_range(0, 6) == 0) begin
                addr = 48'({$urandom, $urandom});
            end else begin
                addr = (tag_pool[$urandom_range(0, pool_size - 1)] << (s + offset_bits)) |
                       (48'($urandom_range(0, last_set)) << offset_bits) |
                       (48'({$urandom, $urandom}) & ((48'd1 << offset_bits) - 48'd1));
            end
            offer_access(2'($urandom_range(0, 3)), addr);
        end
    endtask

    // Main sequence: reset, directed accesses, then random phases.
    initial begin : stimulus
        int k;
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset setting, one way: hits, a refill on a conflict, all access kinds,
        // extreme and alternating addresses.
        offer_access(OP_LOAD, 48'h0);
        offer_access(OP_LOAD, 48'hF);
        offer_access(OP_STORE, 48'h100);
        offer_access(OP_MODIFY, 48'h0);
        offer_access(OP_MODIFY_ALT, 48'h8);
        offer_access(OP_LOAD, 48'hFFFF_FFFF_FFFF);
        offer_access(OP_STORE, 48'hFFFF_FFFF_FFF0);
        offer_access(OP_LOAD, 48'h5555_5555_5555);
        offer_access(OP_LOAD, 48'hAAAA_AAAA_AAAA);

        // Four sets of four ways: fill set 0, refresh one line, then two evictions
        // that follow the LRU order.
        drain();
        write_config(4'd2, 4'd4, 4'd4);
        for (k = 1; k <= 4; k++) begin
            offer_access(OP_LOAD, 48'(k) << 6);
        end
        offer_access(OP_LOAD, 48'd2 << 6);
        offer_access(OP_STORE, 48'd5 << 6);
        offer_access(OP_LOAD, 48'd1 << 6);

        // Shrinking to one way hides the upper ways; growing back leaves a duplicate
        // tag, and the lowest-numbered match must win.
        drain();
        write_config(4'd2, 4'd4, 4'd1);
        offer_access(OP_LOAD, 48'd2 << 6);
        drain();
        write_config(4'd2, 4'd4, 4'd4);
        offer_access(OP_LOAD, 48'd2 << 6);
        offer_access(OP_MODIFY, 48'd5 << 6);

        // Random phases, extremes of every register first.
        run_phase(4'd0, 4'd0, 4'd1, 45, 1'b0);
        run_phase(4'd15, 4'd15, 4'd15, 45, 1'b0);
        run_phase(4'd8, 4'd12, 4'd8, 50, 1'b1);
        run_phase(4'd1, 4'd13, 4'd0, 40, 1'b0);
        run_phase(4'd3, 4'd6, 4'd2, 45, 1'b0);
        run_phase(4'd9, 4'd14, 4'd9, 45, 1'b0);
        run_phase(4'd2, 4'd3, 4'd4, 50, 1'b0);
        for (k = 0; k < 5; k++) begin
            run_phase(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                      4'($urandom_range(0, 15)), 45, 1'b0);
        end

        drain();
        repeat (DRAIN_TAIL_CYCLES) @(posedge aclk);

        $display("Checked %0d accesses over %0d register settings:",
                 sb.hit_count + sb.fill_count + sb.evict_count, settings_used);
        $display("  %0d hits, %0d fills, %0d evictions.",
                 sb.hit_count, sb.fill_count, sb.evict_count);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: set_assoc_cache_lru_sim.f
rtl/sacl_pkg.sv
rtl/sacl_tag_store.sv
rtl/sacl_meta_store.sv
rtl/sacl_lru_update.sv
rtl/set_assoc_cache_lru_sim.sv
dv/set_assoc_cache_lru_sim_tb.sv
